// File: hdl/pwkf_pkg.sv
// Shared types, codes and helpers for the pulse-width key frame sender.
// Used by pwkf_core and pulse_width_key_frame_sender_core; depends on nothing.
`default_nettype none

package pwkf_pkg;

  localparam int unsigned WordW  = 16;
  localparam int unsigned TicksW = 16;
  localparam int unsigned BitIdxW = 4;
  localparam int unsigned SubW    = 2;
  localparam int unsigned CfgIdxW = 2;

  localparam logic [BitIdxW-1:0] LastBit = 4'd15;
  localparam logic [SubW-1:0]    LastSub = 2'd3;

  localparam logic [TicksW-1:0] PeriodReset = 16'd500;
  localparam logic [TicksW-1:0] HeaderReset = 16'd5000;
  localparam logic [TicksW-1:0] GapReset    = 16'd10000;

  typedef enum logic [1:0] {
    FUNC_TICK = 2'd0,
    FUNC_RAW  = 2'd1,
    FUNC_KEY  = 2'd2,
    FUNC_NONE = 2'd3
  } func_e;

  typedef enum logic [1:0] {
    PH_IDLE   = 2'd0,
    PH_HEADER = 2'd1,
    PH_BITS   = 2'd2,
    PH_GAP    = 2'd3
  } phase_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_PERIOD = 2'd0,
    CFG_HEADER = 2'd1,
    CFG_GAP    = 2'd2,
    CFG_UNUSED = 2'd3
  } cfg_idx_e;

  typedef struct packed {
    logic line_level;
    logic busy;
    logic frame_done;
    logic start_rejected;
  } res_t;

  typedef struct packed {
    logic [TicksW-1:0] period_ticks;
    logic [TicksW-1:0] header_ticks;
    logic [TicksW-1:0] gap_ticks;
  } cfg_t;

  // Status in the top three bits, key below it, and a low byte that is the
  // complement of the high byte.
  function automatic logic [WordW-1:0] build_key_word(input logic [2:0] status,
                                                      input logic [4:0] key);
    logic [7:0] hi;
    hi = {status, key};
    return {hi, ~hi};
  endfunction

endpackage

`default_nettype wire

// File: hdl/pwkf_core.sv
// Frame sequencer: phase, bit and tick counters and the line level.
// Depends on pwkf_pkg. Updates its state once per processed item.
`default_nettype none

module pwkf_core (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               en_i,
  input  wire logic [1:0]                         func_i,
  input  wire logic [pwkf_pkg::WordW-1:0]         frame_word_i,
  input  wire logic [2:0]                         key_status_i,
  input  wire logic [4:0]                         key_code_i,
  input  wire pwkf_pkg::cfg_t                     cfg_i,
  output pwkf_pkg::res_t                          res_o
);

  pwkf_pkg::phase_e                   phase_q, phase_d;
  logic [pwkf_pkg::WordW-1:0]         word_q, word_d;
  logic [pwkf_pkg::BitIdxW-1:0]       bit_idx_q, bit_idx_d;
  logic [pwkf_pkg::SubW-1:0]          sub_q, sub_d;
  logic [pwkf_pkg::TicksW-1:0]        tick_q, tick_d;
  logic                               level_q, level_d;

  pwkf_pkg::func_e                    func;
  logic [pwkf_pkg::TicksW-1:0]        limit;
  logic [pwkf_pkg::TicksW-1:0]        tick_inc;
  logic                               reached;
  logic                               is_start;
  logic [pwkf_pkg::SubW-1:0]          sub_inc;
  logic                               cur_bit;

  assign func     = pwkf_pkg::func_e'(func_i);
  assign is_start = (func == pwkf_pkg::FUNC_RAW) || (func == pwkf_pkg::FUNC_KEY);
  assign tick_inc = tick_q + 1'b1;
  assign sub_inc  = sub_q + 1'b1;
  assign cur_bit  = word_q[pwkf_pkg::LastBit - bit_idx_q];

  always_comb begin
    case (phase_q)
      pwkf_pkg::PH_HEADER: limit = cfg_i.header_ticks;
      pwkf_pkg::PH_BITS:   limit = cfg_i.period_ticks;
      default:             limit = cfg_i.gap_ticks;
    endcase
  end

  // A count that wraps to zero also ends the phase.
  assign reached = (tick_inc >= limit) || (tick_inc == '0);

  // Next phase.
  always_comb begin
    phase_d = phase_q;
    if (is_start) begin
      if (phase_q == pwkf_pkg::PH_IDLE) begin
        phase_d = pwkf_pkg::PH_HEADER;
      end
    end else if (func == pwkf_pkg::FUNC_TICK && reached) begin
      case (phase_q)
        pwkf_pkg::PH_HEADER: phase_d = pwkf_pkg::PH_BITS;
        pwkf_pkg::PH_BITS: begin
          if (sub_q == pwkf_pkg::LastSub && bit_idx_q == pwkf_pkg::LastBit) begin
            phase_d = (cfg_i.gap_ticks == '0) ? pwkf_pkg::PH_IDLE : pwkf_pkg::PH_GAP;
          end
        end
        pwkf_pkg::PH_GAP: phase_d = pwkf_pkg::PH_IDLE;
        default:          phase_d = phase_q;
      endcase
    end
  end

  // Datapath and result flags.
  always_comb begin
    word_d    = word_q;
    bit_idx_d = bit_idx_q;
    sub_d     = sub_q;
    tick_d    = tick_q;
    level_d   = level_q;
    res_o.frame_done     = 1'b0;
    res_o.start_rejected = 1'b0;
    if (is_start) begin
      if (phase_q != pwkf_pkg::PH_IDLE) begin
        res_o.start_rejected = 1'b1;
      end else begin
        word_d    = (func == pwkf_pkg::FUNC_RAW) ? frame_word_i
                  : pwkf_pkg::build_key_word(key_status_i, key_code_i);
        bit_idx_d = '0;
        sub_d     = '0;
        tick_d    = '0;
        level_d   = 1'b0;
      end
    end else if (func == pwkf_pkg::FUNC_TICK) begin
      case (phase_q)
        pwkf_pkg::PH_HEADER: begin
          tick_d = reached ? '0 : tick_inc;
          if (reached) begin
            bit_idx_d = '0;
            sub_d     = '0;
            level_d   = 1'b1;
          end
        end
        pwkf_pkg::PH_BITS: begin
          tick_d = reached ? '0 : tick_inc;
          if (reached) begin
            if (sub_q == pwkf_pkg::LastSub) begin
              sub_d   = '0;
              level_d = 1'b1;
              if (bit_idx_q == pwkf_pkg::LastBit) begin
                res_o.frame_done = 1'b1;
                bit_idx_d        = '0;
              end else begin
                bit_idx_d = bit_idx_q + 1'b1;
              end
            end else begin
              sub_d   = sub_inc;
              level_d = (sub_inc == pwkf_pkg::LastSub) ? 1'b0 : cur_bit;
            end
          end
        end
        pwkf_pkg::PH_GAP: begin
          tick_d  = reached ? '0 : tick_inc;
          level_d = 1'b1;
        end
        default: level_d = 1'b1;
      endcase
    end
    res_o.line_level = level_d;
    res_o.busy       = (phase_d != pwkf_pkg::PH_IDLE);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= pwkf_pkg::PH_IDLE;
      word_q    <= '0;
      bit_idx_q <= '0;
      sub_q     <= '0;
      tick_q    <= '0;
      level_q   <= 1'b1;
    end else if (en_i) begin
      phase_q   <= phase_d;
      word_q    <= word_d;
      bit_idx_q <= bit_idx_d;
      sub_q     <= sub_d;
      tick_q    <= tick_d;
      level_q   <= level_d;
    end
  end

endmodule

`default_nettype wire

// File: hdl/pulse_width_key_frame_sender_core.sv
// Two registers lie between input transfer and result valid (input register,
// then result register). Throughput: one item per cycle when out_stall_i is low.
// The rate is set by the single sequencer step between the two registers.
// Reset clears the pipeline valids, sets the sequencer's line level to idle high
// and loads the register defaults: period 500, header 5000, gap 10000 ticks.
// Top level of the pulse-width key frame sender; depends on pwkf_pkg, pwkf_core.
`default_nettype none

module pulse_width_key_frame_sender_core (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [1:0]  cfg_idx_i,
  input  wire logic [15:0] cfg_data_i,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [1:0]  func_i,
  input  wire logic [15:0] frame_word_i,
  input  wire logic [2:0]  key_status_i,
  input  wire logic [4:0]  key_code_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic             line_level_o,
  output logic             busy_res_o,
  output logic             frame_done_o,
  output logic             start_rejected_o
);

  pwkf_pkg::cfg_t   cfg_q;
  logic             s1_valid_q;
  logic [1:0]       s1_func_q;
  logic [15:0]      s1_word_q;
  logic [2:0]       s1_status_q;
  logic [4:0]       s1_key_q;
  logic             out_valid_q;
  pwkf_pkg::res_t   res_q, res_d;
  logic             out_free;
  logic             s1_move;
  logic             in_take;

  assign out_free   = !out_valid_q || !out_stall_i;
  assign s1_move    = s1_valid_q && out_free;
  assign in_stall_o = s1_valid_q && !out_free;
  assign in_take    = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.period_ticks <= pwkf_pkg::PeriodReset;
      cfg_q.header_ticks <= pwkf_pkg::HeaderReset;
      cfg_q.gap_ticks    <= pwkf_pkg::GapReset;
    end else if (cfg_we_i) begin
      case (pwkf_pkg::cfg_idx_e'(cfg_idx_i))
        pwkf_pkg::CFG_PERIOD: cfg_q.period_ticks <= cfg_data_i;
        pwkf_pkg::CFG_HEADER: cfg_q.header_ticks <= cfg_data_i;
        pwkf_pkg::CFG_GAP:    cfg_q.gap_ticks    <= cfg_data_i;
        default:              cfg_q              <= cfg_q;
      endcase
    end
  end

  // Input register stage.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_take || s1_move) begin
      s1_valid_q <= in_take;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      s1_func_q   <= func_i;
      s1_word_q   <= frame_word_i;
      s1_status_q <= key_status_i;
      s1_key_q    <= key_code_i;
    end
  end

  pwkf_core u_core (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .en_i         (s1_move),
    .func_i       (s1_func_q),
    .frame_word_i (s1_word_q),
    .key_status_i (s1_status_q),
    .key_code_i   (s1_key_q),
    .cfg_i        (cfg_q),
    .res_o        (res_d)
  );

  // Result register; a stalled result holds until its transfer completes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_move) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign line_level_o     = res_q.line_level;
  assign busy_res_o       = res_q.busy;
  assign frame_done_o     = res_q.frame_done;
  assign start_rejected_o = res_q.start_rejected;

endmodule

`default_nettype wire
